// ----- src/ems_pkg.sv -----
// ----------------------------------------------------------------------------
// ems_pkg: shared types and constants of the multichannel smoother
// Register indexes, channel kinds, the Q1.15 unity factor and the
// configuration bundle passed from the register file to the datapath.
// ----------------------------------------------------------------------------
package ems_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FACTOR_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CHANNEL_W = 7;
   localparam int KIND_W = 3;

   localparam logic [FACTOR_W-1:0] ONE_Q15 = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILTER_ENABLE      = 3'd0,
      REG_FACTOR_TEMPERATURE = 3'd1,
      REG_FACTOR_SN          = 3'd2,
      REG_FACTOR_LEVEL       = 3'd3,
      REG_FACTOR_SPEED       = 3'd4
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TEMPERATURE = 3'd0,
      KIND_SN          = 3'd1,
      KIND_LEVEL       = 3'd2,
      KIND_SPEED       = 3'd3,
      KIND_LENGTH      = 3'd4
   } kind_type;

   typedef struct packed {
      logic                filter_enable;
      logic [FACTOR_W-1:0] factor_temperature;
      logic [FACTOR_W-1:0] factor_sn;
      logic [FACTOR_W-1:0] factor_level;
      logic [FACTOR_W-1:0] factor_speed;
   } cfg_type;

endpackage

// ----- src/multichannel_exponential_smoother_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_exponential_smoother_top: per-channel first-order smoother
// An accepted request is held in the input stage, then in the output register.
// Throughput: one request per cycle while the output is not stalled, including back-to-back same channel.
// Reset: synchronous; afterwards a clearing pass over all CHANNELS entries resets
// the history memory's first-sample flags, with req_stall held high.
// ----------------------------------------------------------------------------
module multichannel_exponential_smoother_top #(
   parameter int CHANNELS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ems_pkg::CHANNEL_W-1:0]       req_channel,
   input  logic signed [ems_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_channel_valid,
   input  logic [ems_pkg::KIND_W-1:0]          req_channel_kind,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ems_pkg::CHANNEL_W-1:0]       rsp_out_channel,
   output logic signed [ems_pkg::SAMPLE_W-1:0] rsp_smoothed,
   output logic signed [ems_pkg::SAMPLE_W-1:0] rsp_raw_echo,
   input  logic                                csr_write_enable,
   input  logic [ems_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ems_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NUM_CH_CODES = 1 << ems_pkg::CHANNEL_W;
   localparam int ENTRY_W = ems_pkg::SAMPLE_W + 1;

   ems_pkg::cfg_type cfg;

   logic [IDX_W-1:0] wrap_lut [NUM_CH_CODES];
   for (genvar g = 0; g < NUM_CH_CODES; g++) begin : g_wrap
      assign wrap_lut[g] = IDX_W'(g % CHANNELS);
   end

   logic                                req_accept;
   logic                                s1_fire;
   logic                                out_free;
   logic [IDX_W-1:0]                    req_index;

   logic                                clearing_ff, clearing_in;
   logic [IDX_W-1:0]                    clr_cnt_ff, clr_cnt_in;

   logic                                s1_valid_ff, s1_valid_in;
   logic [ems_pkg::CHANNEL_W-1:0]       s1_channel_ff;
   logic [IDX_W-1:0]                    s1_index_ff;
   logic signed [ems_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                                s1_chvalid_ff;
   logic [ems_pkg::KIND_W-1:0]          s1_kind_ff;

   logic [ENTRY_W-1:0]                  hist_mem [CHANNELS];
   logic [ENTRY_W-1:0]                  rd_data_ff;

   logic                                lw_valid_ff, lw_valid_in;
   logic [IDX_W-1:0]                    lw_index_ff;
   logic [ENTRY_W-1:0]                  lw_data_ff;

   logic [ENTRY_W-1:0]                  entry_old;
   logic signed [ems_pkg::SAMPLE_W-1:0] history_new;
   logic signed [ems_pkg::SAMPLE_W-1:0] result;

   logic                                wr_en;
   logic [IDX_W-1:0]                    wr_addr;
   logic [ENTRY_W-1:0]                  wr_data;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ems_pkg::CHANNEL_W-1:0]       rsp_channel_ff;
   logic signed [ems_pkg::SAMPLE_W-1:0] rsp_smoothed_ff;
   logic signed [ems_pkg::SAMPLE_W-1:0] rsp_raw_ff;

   ems_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = clearing_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;
   assign req_index  = wrap_lut[req_channel];

   assign clearing_in = clearing_ff && (clr_cnt_ff != IDX_W'(CHANNELS - 1));
   assign clr_cnt_in  = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign s1_valid_in = req_accept || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_channel_ff <= req_channel;
         s1_index_ff   <= req_index;
         s1_sample_ff  <= req_sample;
         s1_chvalid_ff <= req_channel_valid;
         s1_kind_ff    <= req_channel_kind;
      end
   end

   // Each entry holds the first-sample flag above the 16-bit history.
   assign wr_en   = clearing_ff || s1_fire;
   assign wr_addr = clearing_ff ? clr_cnt_ff : s1_index_ff;
   assign wr_data = clearing_ff ? '0 : {1'b1, history_new};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (req_accept) begin
         rd_data_ff <= hist_mem[req_index];
      end
   end

   // The write made at the edge where a request enters is not yet in its
   // read data, so it is forwarded from the last-write register.
   assign lw_valid_in = lw_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else begin
         lw_valid_ff <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         lw_index_ff <= s1_index_ff;
         lw_data_ff  <= {1'b1, history_new};
      end
   end

   assign entry_old = (lw_valid_ff && (lw_index_ff == s1_index_ff)) ? lw_data_ff
                                                                    : rd_data_ff;

   ems_update u_update (
      .cfg           (cfg),
      .kind          (s1_kind_ff),
      .channel_valid (s1_chvalid_ff),
      .seen          (entry_old[ems_pkg::SAMPLE_W]),
      .history_old   (entry_old[ems_pkg::SAMPLE_W-1:0]),
      .sample        (s1_sample_ff),
      .history_new   (history_new),
      .result        (result)
   );

   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_channel_ff  <= s1_channel_ff;
         rsp_smoothed_ff <= result;
         rsp_raw_ff      <= s1_sample_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_smoothed    = rsp_smoothed_ff;
   assign rsp_raw_echo    = rsp_raw_ff;

   a_clear_blocks_work: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("request in flight during clearing pass");

   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff && (s1_channel_ff == $past(req_channel)))
      else $error("accepted request not held in input stage");

   a_s1_to_output: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff && (rsp_out_channel == $past(s1_channel_ff))
                  && (rsp_raw_echo == $past(s1_sample_ff)))
      else $error("input stage did not reach the output register");

   a_bypass_when_off: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !cfg.filter_enable |=> rsp_smoothed == rsp_raw_echo)
      else $error("filter off but result differs from raw sample");

endmodule

// ----- src/ems_csr.sv -----
// ----------------------------------------------------------------------------
// ems_csr: configuration registers
// Holds the enable bit and the four Q1.15 factors. Factors above unity are
// saturated to unity as they are written.
// ----------------------------------------------------------------------------
module ems_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [ems_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ems_pkg::CSR_DATA_W-1:0] csr_write_data,
   output ems_pkg::cfg_type               cfg
);

   ems_pkg::cfg_type               cfg_ff;
   ems_pkg::cfg_type               cfg_in;
   logic [ems_pkg::FACTOR_W-1:0]   factor_sat;

   assign factor_sat = (csr_write_data > ems_pkg::ONE_Q15) ? ems_pkg::ONE_Q15
                                                           : csr_write_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ems_pkg::REG_FILTER_ENABLE:      cfg_in.filter_enable = csr_write_data[0];
            ems_pkg::REG_FACTOR_TEMPERATURE: cfg_in.factor_temperature = factor_sat;
            ems_pkg::REG_FACTOR_SN:          cfg_in.factor_sn = factor_sat;
            ems_pkg::REG_FACTOR_LEVEL:       cfg_in.factor_level = factor_sat;
            ems_pkg::REG_FACTOR_SPEED:       cfg_in.factor_speed = factor_sat;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_enable      <= 1'b0;
         cfg_ff.factor_temperature <= ems_pkg::ONE_Q15;
         cfg_ff.factor_sn          <= ems_pkg::ONE_Q15;
         cfg_ff.factor_level       <= ems_pkg::ONE_Q15;
         cfg_ff.factor_speed       <= ems_pkg::ONE_Q15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/ems_update.sv -----
// ----------------------------------------------------------------------------
// ems_update: per-request filter arithmetic
// Picks the factor by channel kind and computes the new history value and
// the result from the previous history, its first-sample flag and the sample.
// ----------------------------------------------------------------------------
module ems_update (
   input  ems_pkg::cfg_type                    cfg,
   input  logic [ems_pkg::KIND_W-1:0]          kind,
   input  logic                                channel_valid,
   input  logic                                seen,
   input  logic signed [ems_pkg::SAMPLE_W-1:0] history_old,
   input  logic signed [ems_pkg::SAMPLE_W-1:0] sample,
   output logic signed [ems_pkg::SAMPLE_W-1:0] history_new,
   output logic signed [ems_pkg::SAMPLE_W-1:0] result
);

   logic [ems_pkg::FACTOR_W-1:0]         factor;
   logic signed [ems_pkg::SAMPLE_W-1:0]  base;
   logic signed [ems_pkg::SAMPLE_W:0]    diff;
   logic signed [2*ems_pkg::SAMPLE_W+1:0] prod;
   logic signed [2*ems_pkg::SAMPLE_W+2:0] acc;
   logic signed [2*ems_pkg::SAMPLE_W+2:0] acc_adj;
   logic signed [2*ems_pkg::SAMPLE_W+2:0] quot;

   always_comb begin
      case (kind)
         ems_pkg::KIND_SN:     factor = cfg.factor_sn;
         ems_pkg::KIND_LEVEL:  factor = cfg.factor_level;
         ems_pkg::KIND_SPEED:  factor = cfg.factor_speed;
         ems_pkg::KIND_LENGTH: factor = ems_pkg::ONE_Q15;
         default:              factor = cfg.factor_temperature;
      endcase
   end

   // On a channel's first request the history starts from the sample.
   assign base = seen ? history_old : sample;

   // old*(1-f) + s*f is formed as old*2^15 + (s-old)*f with one multiplier.
   assign diff    = 17'(sample) - 17'(base);
   assign prod    = diff * $signed({1'b0, factor});
   assign acc     = (35'(base) <<< 15) + 35'(prod);
   assign acc_adj = acc + (acc[2*ems_pkg::SAMPLE_W+2] ? 35'sd32767 : 35'sd0);
   assign quot    = acc_adj >>> 15;

   always_comb begin
      if (!cfg.filter_enable) begin
         history_new = sample;
         result      = sample;
      end else if (channel_valid) begin
         history_new = quot[ems_pkg::SAMPLE_W-1:0];
         result      = quot[ems_pkg::SAMPLE_W-1:0];
      end else begin
         history_new = base;
         result      = base;
      end
   end

endmodule
